/* rtl/phlt_pkg.sv */
`default_nettype none

package phlt_pkg;

  // sizing
  localparam int MAX_SPAN   = 16;
  localparam int PRICE_W    = 32;
  localparam int INDEX_W    = 32;
  localparam int HIST_DEPTH = 2 * MAX_SPAN + 1;
  localparam int HIST_IW    = $clog2(HIST_DEPTH);
  localparam int SPAN_IW    = $clog2(MAX_SPAN + 1);

  // configuration port
  localparam int CFG_SPAN_W  = 5;
  localparam int CFG_LOOK_W  = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LEFT_SPAN     = 2'd0,
    CFG_RIGHT_SPAN    = 2'd1,
    CFG_LOOKBACK_BARS = 2'd2
  } cfg_reg_t;

  typedef logic signed [PRICE_W-1:0] price_t;
  typedef logic [INDEX_W-1:0]        idx_t;
  typedef logic [SPAN_IW-1:0]        span_t;
  typedef logic [HIST_IW-1:0]        tap_t;

  // handover from the history stage to the pivot stage
  typedef struct packed {
    logic valid;
    idx_t idx;
  } stage_t;

  // one result item
  typedef struct packed {
    price_t pivot_high_price;
    price_t pivot_low_price;
    logic   is_new_high;
    logic   is_new_low;
    price_t line_price;
    idx_t   line_index;
    price_t prev_high_price;
    price_t prev_low_price;
    logic   prev_high_present;
    logic   prev_low_present;
    logic   last_high_present;
    logic   last_low_present;
  } res_t;

  // a span of zero acts as one, anything above the maximum as the maximum
  function automatic span_t clamp_span(logic [CFG_SPAN_W-1:0] s);
    span_t v;
    if (s == '0) begin
      v = span_t'(1);
    end else if (int'(s) > MAX_SPAN) begin
      v = span_t'(MAX_SPAN);
    end else begin
      v = span_t'(s);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/phlt_in_if.sv */
`default_nettype none

interface phlt_in_if;
  logic                   valid;
  logic                   ready;
  phlt_pkg::price_t       bar_high;
  phlt_pkg::price_t       bar_low;

  modport source (output valid, output bar_high, output bar_low, input ready);
  modport sink   (input valid, input bar_high, input bar_low, output ready);
endinterface

`default_nettype wire

/* rtl/phlt_out_if.sv */
`default_nettype none

interface phlt_out_if;
  logic             valid;
  logic             ready;
  phlt_pkg::price_t pivot_high_price;
  phlt_pkg::price_t pivot_low_price;
  logic             is_new_high;
  logic             is_new_low;
  phlt_pkg::price_t line_price;
  phlt_pkg::idx_t   line_index;
  phlt_pkg::price_t prev_high_price;
  phlt_pkg::price_t prev_low_price;
  logic             prev_high_present;
  logic             prev_low_present;
  logic             last_high_present;
  logic             last_low_present;

  modport source (
    output valid, input ready,
    output pivot_high_price, output pivot_low_price, output is_new_high, output is_new_low,
    output line_price, output line_index, output prev_high_price, output prev_low_price,
    output prev_high_present, output prev_low_present,
    output last_high_present, output last_low_present
  );
  modport sink (
    input valid, output ready,
    input pivot_high_price, input pivot_low_price, input is_new_high, input is_new_low,
    input line_price, input line_index, input prev_high_price, input prev_low_price,
    input prev_high_present, input prev_low_present,
    input last_high_present, input last_low_present
  );
endinterface

`default_nettype wire

/* rtl/phlt_hist.sv */
`default_nettype none

// Bar history shift line and bar counter; acts as the input register stage.
module phlt_hist (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire phlt_pkg::price_t  in_high,
  input  wire phlt_pkg::price_t  in_low,
  input  wire logic              take,
  output phlt_pkg::stage_t       stage,
  output phlt_pkg::price_t       hist_high [phlt_pkg::HIST_DEPTH],
  output phlt_pkg::price_t       hist_low  [phlt_pkg::HIST_DEPTH]
);
  import phlt_pkg::*;

  price_t high_r [HIST_DEPTH];
  price_t low_r  [HIST_DEPTH];
  idx_t   bar_count_r;
  idx_t   idx_r;
  logic   valid_r;
  logic   accept;

  // stage is free when empty or when its item moves on this cycle
  assign in_ready = !valid_r || take;
  assign accept   = in_valid && in_ready;

  // shift line, newest bar at tap 0
  always_ff @(posedge clk) begin
    if (accept) begin
      high_r[0] <= in_high;
      low_r[0]  <= in_low;
      for (int k = 1; k < HIST_DEPTH; k++) begin
        high_r[k] <= high_r[k-1];
        low_r[k]  <= low_r[k-1];
      end
      idx_r <= bar_count_r;
    end
  end

  // control: occupancy and saturating bar counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      bar_count_r <= '0;
    end else begin
      if (accept) begin
        valid_r <= 1'b1;
        if (bar_count_r != '1) begin
          bar_count_r <= bar_count_r + idx_t'(1);
        end
      end else if (take) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign stage.valid = valid_r;
  assign stage.idx   = idx_r;
  assign hist_high   = high_r;
  assign hist_low    = low_r;

endmodule

`default_nettype wire

/* rtl/phlt_core.sv */
`default_nettype none

// Pivot test, pivot store, window checks and the result register.
module phlt_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [phlt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [phlt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire phlt_pkg::stage_t               stage,
  input  wire phlt_pkg::price_t               hist_high [phlt_pkg::HIST_DEPTH],
  input  wire phlt_pkg::price_t               hist_low  [phlt_pkg::HIST_DEPTH],
  output logic                                take,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output phlt_pkg::res_t                      out_res
);
  import phlt_pkg::*;

  // configuration
  logic [CFG_SPAN_W-1:0] left_span_r;
  logic [CFG_SPAN_W-1:0] right_span_r;
  logic [CFG_LOOK_W-1:0] lookback_r;

  // pivot store
  price_t last_high_val_r, older_high_val_r, last_low_val_r, older_low_val_r;
  idx_t   last_high_pos_r, older_high_pos_r, last_low_pos_r, older_low_pos_r;
  logic   last_high_vld_r, older_high_vld_r, last_low_vld_r, older_low_vld_r;

  price_t last_high_val_nxt, older_high_val_nxt, last_low_val_nxt, older_low_val_nxt;
  idx_t   last_high_pos_nxt, older_high_pos_nxt, last_low_pos_nxt, older_low_pos_nxt;
  logic   last_high_vld_nxt, older_high_vld_nxt, last_low_vld_nxt, older_low_vld_nxt;

  logic   out_valid_r;
  res_t   res_r;
  res_t   res_nxt;

  span_t  l_span, r_span;
  tap_t   r_tap, lr_sum;
  idx_t   centre_idx;
  price_t centre_high, centre_low;
  logic   tested, is_h, is_l;
  logic   win_c, win_lh, win_oh, win_ll, win_ol;
  logic   nwin_lh, nwin_oh, nwin_ll, nwin_ol;
  logic   lh, ll, ph, pl;
  logic   fire;

  function automatic logic in_window(idx_t idx, idx_t pos, logic [CFG_LOOK_W-1:0] lb);
    idx_t age;
    age = idx - pos;
    return (lb == '0) || (age < lb);
  endfunction

  assign take = !out_valid_r || out_ready;
  assign fire = stage.valid && take;

  // configuration register decoder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_span_r  <= CFG_SPAN_W'(1);
      right_span_r <= CFG_SPAN_W'(1);
      lookback_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEFT_SPAN:     left_span_r  <= cfg_data[CFG_SPAN_W-1:0];
        CFG_RIGHT_SPAN:    right_span_r <= cfg_data[CFG_SPAN_W-1:0];
        CFG_LOOKBACK_BARS: lookback_r   <= cfg_data[CFG_LOOK_W-1:0];
        default: ;
      endcase
    end
  end

  // centre bar and the strict comparisons against its neighbours
  always_comb begin
    l_span      = clamp_span(left_span_r);
    r_span      = clamp_span(right_span_r);
    r_tap       = tap_t'(r_span);
    lr_sum      = tap_t'(l_span) + tap_t'(r_span);
    tested      = stage.idx >= idx_t'(lr_sum);
    centre_idx  = stage.idx - idx_t'(r_span);
    centre_high = hist_high[0];
    centre_low  = hist_low[0];
    for (int k = 0; k < HIST_DEPTH; k++) begin
      if (tap_t'(k) == r_tap) begin
        centre_high = hist_high[k];
        centre_low  = hist_low[k];
      end
    end
    is_h = tested;
    is_l = tested;
    for (int k = 0; k < HIST_DEPTH; k++) begin
      if (tap_t'(k) != r_tap && tap_t'(k) <= lr_sum) begin
        if (hist_high[k] >= centre_high) is_h = 1'b0;
        if (hist_low[k] <= centre_low)   is_l = 1'b0;
      end
    end
  end

  // window checks on the candidate and on the stored positions, in parallel
  always_comb begin
    win_c  = in_window(stage.idx, centre_idx, lookback_r);
    win_lh = in_window(stage.idx, last_high_pos_r, lookback_r);
    win_oh = in_window(stage.idx, older_high_pos_r, lookback_r);
    win_ll = in_window(stage.idx, last_low_pos_r, lookback_r);
    win_ol = in_window(stage.idx, older_low_pos_r, lookback_r);
  end

  // pivot store update: a new pivot pushes the last one down
  always_comb begin
    last_high_val_nxt  = last_high_val_r;
    last_high_pos_nxt  = last_high_pos_r;
    last_high_vld_nxt  = last_high_vld_r;
    older_high_val_nxt = older_high_val_r;
    older_high_pos_nxt = older_high_pos_r;
    older_high_vld_nxt = older_high_vld_r;
    nwin_lh            = win_lh;
    nwin_oh            = win_oh;
    if (is_h) begin
      if (last_high_vld_r) begin
        older_high_val_nxt = last_high_val_r;
        older_high_pos_nxt = last_high_pos_r;
        older_high_vld_nxt = 1'b1;
        nwin_oh            = win_lh;
      end
      last_high_val_nxt = centre_high;
      last_high_pos_nxt = centre_idx;
      last_high_vld_nxt = 1'b1;
      nwin_lh           = win_c;
    end

    last_low_val_nxt  = last_low_val_r;
    last_low_pos_nxt  = last_low_pos_r;
    last_low_vld_nxt  = last_low_vld_r;
    older_low_val_nxt = older_low_val_r;
    older_low_pos_nxt = older_low_pos_r;
    older_low_vld_nxt = older_low_vld_r;
    nwin_ll           = win_ll;
    nwin_ol           = win_ol;
    if (is_l) begin
      if (last_low_vld_r) begin
        older_low_val_nxt = last_low_val_r;
        older_low_pos_nxt = last_low_pos_r;
        older_low_vld_nxt = 1'b1;
        nwin_ol           = win_ll;
      end
      last_low_val_nxt = centre_low;
      last_low_pos_nxt = centre_idx;
      last_low_vld_nxt = 1'b1;
      nwin_ll          = win_c;
    end
  end

  // result fields; the low wins the line on a tie of positions
  always_comb begin
    lh = last_high_vld_nxt && nwin_lh;
    ll = last_low_vld_nxt && nwin_ll;
    ph = lh && older_high_vld_nxt && nwin_oh;
    pl = ll && older_low_vld_nxt && nwin_ol;

    res_nxt                   = '0;
    res_nxt.pivot_high_price  = lh ? last_high_val_nxt : '0;
    res_nxt.pivot_low_price   = ll ? last_low_val_nxt : '0;
    res_nxt.is_new_high       = is_h && win_c;
    res_nxt.is_new_low        = is_l && win_c;
    res_nxt.prev_high_price   = ph ? older_high_val_nxt : '0;
    res_nxt.prev_low_price    = pl ? older_low_val_nxt : '0;
    res_nxt.prev_high_present = ph;
    res_nxt.prev_low_present  = pl;
    res_nxt.last_high_present = lh;
    res_nxt.last_low_present  = ll;
    if (lh) begin
      res_nxt.line_price = last_high_val_nxt;
      res_nxt.line_index = last_high_pos_nxt;
    end
    if (ll && (!lh || last_low_pos_nxt >= last_high_pos_nxt)) begin
      res_nxt.line_price = last_low_val_nxt;
      res_nxt.line_index = last_low_pos_nxt;
    end
  end

  // pivot store and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_high_val_r  <= '0;
      last_high_pos_r  <= '0;
      last_high_vld_r  <= 1'b0;
      older_high_val_r <= '0;
      older_high_pos_r <= '0;
      older_high_vld_r <= 1'b0;
      last_low_val_r   <= '0;
      last_low_pos_r   <= '0;
      last_low_vld_r   <= 1'b0;
      older_low_val_r  <= '0;
      older_low_pos_r  <= '0;
      older_low_vld_r  <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (fire) begin
        last_high_val_r  <= last_high_val_nxt;
        last_high_pos_r  <= last_high_pos_nxt;
        last_high_vld_r  <= last_high_vld_nxt;
        older_high_val_r <= older_high_val_nxt;
        older_high_pos_r <= older_high_pos_nxt;
        older_high_vld_r <= older_high_vld_nxt;
        last_low_val_r   <= last_low_val_nxt;
        last_low_pos_r   <= last_low_pos_nxt;
        last_low_vld_r   <= last_low_vld_nxt;
        older_low_val_r  <= older_low_val_nxt;
        older_low_pos_r  <= older_low_pos_nxt;
        older_low_vld_r  <= older_low_vld_nxt;
        out_valid_r      <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

/* rtl/pivot_high_low_tracker_top.sv */
`default_nettype none

// Channel   Direction  Handshake         Contents
// in_bar    in         valid / ready     bar_high, bar_low (one price bar per item)
// out_res   out        valid / ready     pivot prices, flags, line price and index
// cfg_*     in         cfg_we only       left_span, right_span, lookback_bars
//
// Two stages: the history shift line registers the bar, then the core tests the
// centre bar and loads the result register. One item per cycle sustained while the
// output is not stalled. Throughput is set by the pivot-store update, which is
// combinational. Synchronous active-low reset clears the counter and pivot store
// and sets both spans to one and lookback to zero; the history needs no clearing.
// A stalled output holds both stages; in_bar.ready drops only when both are full.
module pivot_high_low_tracker_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  phlt_in_if.sink                               in_bar,
  phlt_out_if.source                            out_res,
  input  wire logic                             cfg_we,
  input  wire logic [phlt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [phlt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import phlt_pkg::*;

  stage_t stage;
  price_t hist_high [HIST_DEPTH];
  price_t hist_low  [HIST_DEPTH];
  logic   take;
  logic   in_ready;
  logic   out_valid;
  res_t   res;

  phlt_hist u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bar.valid),
    .in_ready  (in_ready),
    .in_high   (in_bar.bar_high),
    .in_low    (in_bar.bar_low),
    .take      (take),
    .stage     (stage),
    .hist_high (hist_high),
    .hist_low  (hist_low)
  );

  phlt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stage     (stage),
    .hist_high (hist_high),
    .hist_low  (hist_low),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_res.ready),
    .out_res   (res)
  );

  assign in_bar.ready              = in_ready;
  assign out_res.valid             = out_valid;
  assign out_res.pivot_high_price  = res.pivot_high_price;
  assign out_res.pivot_low_price   = res.pivot_low_price;
  assign out_res.is_new_high       = res.is_new_high;
  assign out_res.is_new_low        = res.is_new_low;
  assign out_res.line_price        = res.line_price;
  assign out_res.line_index        = res.line_index;
  assign out_res.prev_high_price   = res.prev_high_price;
  assign out_res.prev_low_price    = res.prev_low_price;
  assign out_res.prev_high_present = res.prev_high_present;
  assign out_res.prev_low_present  = res.prev_low_present;
  assign out_res.last_high_present = res.last_high_present;
  assign out_res.last_low_present  = res.last_low_present;

endmodule

`default_nettype wire
